FILE: design/plob_pkg.sv
package plob_pkg;

  localparam int unsigned PriceW = 32;
  localparam int unsigned QtyW   = 32;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;
  localparam logic SIDE_ASK  = 1'b0;
  localparam logic SIDE_BID  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic              used;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   qty;
  } level_t;

  // command broadcast to every cell of one side
  typedef struct packed {
    logic              go;
    logic              ins;
    logic              upd;
    logic              free_lvl;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   qty;
    logic [QtyW-1:0]   newq;
  } cmd_t;

endpackage

FILE: design/plob_cell.sv
module plob_cell
  import plob_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              is_bid,
  input  logic [PriceW-1:0] key,
  input  cmd_t              cmd,
  input  logic              prev_worse,
  input  level_t            prev_lvl,
  input  level_t            next_lvl,
  output level_t            lvl,
  output logic              worse,
  output logic              match
);

  logic              used_r, used_nxt;
  logic [PriceW-1:0] price_r, price_nxt;
  logic [QtyW-1:0]   qty_r, qty_nxt;

  // cells stay sorted best first, free cells at the tail
  assign worse = !used_r || (is_bid ? (price_r < key) : (price_r > key));
  assign match = used_r && (price_r == key);
  assign lvl   = '{used: used_r, price: price_r, qty: qty_r};

  always_comb begin
    used_nxt  = used_r;
    price_nxt = price_r;
    qty_nxt   = qty_r;
    if (cmd.go) begin
      if (cmd.ins && worse) begin
        if (prev_worse) begin
          used_nxt  = prev_lvl.used;
          price_nxt = prev_lvl.price;
          qty_nxt   = prev_lvl.qty;
        end else begin
          used_nxt  = 1'b1;
          price_nxt = cmd.price;
          qty_nxt   = cmd.qty;
        end
      end else if (cmd.free_lvl && (match || worse)) begin
        used_nxt  = next_lvl.used;
        price_nxt = next_lvl.price;
        qty_nxt   = next_lvl.qty;
      end else if (cmd.upd && match) begin
        qty_nxt = cmd.newq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    price_r <= price_nxt;
    qty_r   <= qty_nxt;
  end

endmodule

FILE: design/plob_side.sv
module plob_side
  import plob_pkg::*;
#(
  parameter int unsigned LEVELS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              is_bid,
  input  logic              go,
  input  logic              is_remove,
  input  logic [PriceW-1:0] price,
  input  logic [QtyW-1:0]   qty,
  output level_t            best,
  output logic              full
);

  level_t                lvls  [LEVELS];
  logic   [LEVELS-1:0]   worse;
  logic   [LEVELS-1:0]   match;
  logic                  any_match;
  logic   [QtyW-1:0]     sel_qty;
  logic   [QtyW:0]       sum;
  logic   [QtyW-1:0]     newq;
  cmd_t                  cmd;

  always_comb begin
    sel_qty = '0;
    for (int k = 0; k < LEVELS; k++) begin
      sel_qty = sel_qty | (match[k] ? lvls[k].qty : '0);
    end
  end

  assign any_match = |match;
  assign sum = is_remove ? ({sel_qty[QtyW-1], sel_qty} - {qty[QtyW-1], qty})
                         : ({sel_qty[QtyW-1], sel_qty} + {qty[QtyW-1], qty});

  // saturate to signed 32 bits
  always_comb begin
    if (sum[QtyW] != sum[QtyW-1]) begin
      newq = sum[QtyW] ? {1'b1, {(QtyW-1){1'b0}}} : {1'b0, {(QtyW-1){1'b1}}};
    end else begin
      newq = sum[QtyW-1:0];
    end
  end

  assign full = !is_remove && !any_match && lvls[LEVELS-1].used;

  assign cmd = '{go:       go,
                 ins:      !is_remove && !any_match && !lvls[LEVELS-1].used,
                 upd:      any_match,
                 free_lvl: is_remove && any_match && (newq == '0),
                 price:    price,
                 qty:      qty,
                 newq:     newq};

  for (genvar k = 0; k < LEVELS; k++) begin : g_cell
    level_t pl, nl;
    logic   pw;
    if (k == 0) begin : g_first
      assign pl = '0;
      assign pw = 1'b0;
    end else begin : g_mid
      assign pl = lvls[k-1];
      assign pw = worse[k-1];
    end
    if (k == LEVELS - 1) begin : g_last
      assign nl = '0;
    end else begin : g_body
      assign nl = lvls[k+1];
    end
    plob_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .is_bid     (is_bid),
      .key        (price),
      .cmd        (cmd),
      .prev_worse (pw),
      .prev_lvl   (pl),
      .next_lvl   (nl),
      .lvl        (lvls[k]),
      .worse      (worse[k]),
      .match      (match[k])
    );
  end

  assign best = lvls[0];

endmodule

FILE: design/price_level_order_book.sv
// channel | ports                                   | flow
// in      | in_valid/in_ready, in_operation, in_side,| one order word
//         | in_quantity, in_price_ticks              |
// out     | out_valid/out_ready, out_bid_*, out_ask_*,| one top-of-book word
//         | out_table_full                           |
// Each word takes an update step for the cell chain of the addressed side
// and a report step that loads the output register; the next word is taken
// in the report step when the output register is free.
// A stalled output holds the block in the report step.
// Reset clears every level's used flag; prices and quantities need no reset.
module price_level_order_book
  import plob_pkg::*;
#(
  parameter int unsigned LEVELS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_operation,
  input  logic                     in_side,
  input  logic signed [QtyW-1:0]   in_quantity,
  input  logic [PriceW-1:0]        in_price_ticks,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_bid_valid,
  output logic [PriceW-1:0]        out_bid_price,
  output logic signed [QtyW-1:0]   out_bid_quantity,
  output logic                     out_ask_valid,
  output logic [PriceW-1:0]        out_ask_price,
  output logic signed [QtyW-1:0]   out_ask_quantity,
  output logic                     out_table_full
);

  state_t            state_r, state_nxt;
  logic              op_r, side_r;
  logic [QtyW-1:0]   qty_r;
  logic [PriceW-1:0] price_r;
  logic              full_r;
  logic              out_valid_r;
  logic              load_out, accept, exec;
  level_t            bid_best, ask_best;
  logic              bid_full, ask_full;

  assign load_out = (state_r == ST_REPORT) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == ST_IDLE) || load_out;
  assign accept   = in_valid && in_ready;
  assign exec     = (state_r == ST_EXEC);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_EXEC;
      ST_EXEC:   state_nxt = ST_REPORT;
      ST_REPORT: if (load_out) state_nxt = accept ? ST_EXEC : ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_operation;
      side_r  <= in_side;
      qty_r   <= in_quantity;
      price_r <= in_price_ticks;
    end
    if (exec) begin
      full_r <= (side_r == SIDE_BID) ? bid_full : ask_full;
    end
    if (load_out) begin
      out_bid_valid    <= bid_best.used;
      out_bid_price    <= bid_best.used ? bid_best.price : '0;
      out_bid_quantity <= bid_best.used ? bid_best.qty : '0;
      out_ask_valid    <= ask_best.used;
      out_ask_price    <= ask_best.used ? ask_best.price : '0;
      out_ask_quantity <= ask_best.used ? ask_best.qty : '0;
      out_table_full   <= full_r;
    end
  end

  assign out_valid = out_valid_r;

  plob_side #(.LEVELS(LEVELS)) u_bid (
    .clk       (clk),
    .rst_n     (rst_n),
    .is_bid    (SIDE_BID),
    .go        (exec && (side_r == SIDE_BID)),
    .is_remove (op_r == OP_REMOVE),
    .price     (price_r),
    .qty       (qty_r),
    .best      (bid_best),
    .full      (bid_full)
  );

  plob_side #(.LEVELS(LEVELS)) u_ask (
    .clk       (clk),
    .rst_n     (rst_n),
    .is_bid    (SIDE_ASK),
    .go        (exec && (side_r == SIDE_ASK)),
    .is_remove (op_r == OP_REMOVE),
    .price     (price_r),
    .qty       (qty_r),
    .best      (ask_best),
    .full      (ask_full)
  );

  a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_EXEC)
    else $error("accepted word did not start an update");

  a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    exec |-> !in_ready)
    else $error("input ready during update");

  a_full_only_on_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REPORT) && full_r |-> op_r == OP_ADD)
    else $error("table full flagged on a remove");

  a_empty_bid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_bid_valid |-> out_bid_price == '0 && out_bid_quantity == '0)
    else $error("empty bid side reports nonzero level");

endmodule
